// ----- sv/swog_pkg.sv -----
// ----------------------------------------------------------------------------
// swog_pkg
// shared widths, register indexes and structs of the scanline wave offset
// generator
// ----------------------------------------------------------------------------
package swog_pkg;

	localparam int ANGLE_W    = 12;
	localparam int ANGLE_BITS = 12;
	localparam int AMP_W      = 9;
	localparam int TIMER_W    = 11;
	localparam int SINE_W     = 13;
	localparam int ROM_DEPTH  = 1025;
	localparam int ROM_AW     = 11;
	localparam int LINE_W     = 8;
	localparam int BASE_W     = 10;
	localparam int XOFF_W     = 11;
	localparam int CIDX_W     = 3;
	localparam int CDATA_W    = 12;

	// angle bits below the resolution are dropped before the table lookup
	localparam logic [ANGLE_W-1:0] ANGLE_MASK =
		~ANGLE_W'((32'd1 << (ANGLE_W - ANGLE_BITS)) - 32'd1);

	localparam logic [ANGLE_W-1:0] ANG_QUARTER = 12'd1024;
	localparam logic [ANGLE_W-1:0] ANG_HALF    = 12'd2048;
	localparam logic [ANGLE_W-1:0] ANG_3QUART  = 12'd3072;
	localparam logic [ANGLE_W:0]   ANG_TURN    = 13'h1000;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_BASE_OFFSET = 3'd0;
	localparam logic [CIDX_W-1:0] REG_LINE_STEP   = 3'd1;
	localparam logic [CIDX_W-1:0] REG_FRAME_STEP  = 3'd2;
	localparam logic [CIDX_W-1:0] REG_HOLD_FRAMES = 3'd3;
	localparam logic [CIDX_W-1:0] REG_RAMP_INTVL  = 3'd4;
	localparam logic [CIDX_W-1:0] REG_PEAK_AMP    = 3'd5;

	typedef struct packed {
		logic [BASE_W-1:0]  base_offset;
		logic [ANGLE_W-1:0] line_phase_step;
		logic [ANGLE_W-1:0] frame_phase_step;
		logic [9:0]         hold_frames;
		logic [3:0]         ramp_interval;
		logic [7:0]         peak_amplitude;
	} cfg_t;

	typedef struct packed {
		logic [AMP_W-1:0]   amplitude;
		logic [ANGLE_W-1:0] wave_phase;
	} env_t;

endpackage

// ----- sv/swog_sine_rom.sv -----
// ----------------------------------------------------------------------------
// swog_sine_rom
// quarter-wave sine table, round(4096*sin(k*pi/2048)) for k = 0..1024,
// with a registered read port
// ----------------------------------------------------------------------------
module swog_sine_rom (
	input  logic                        clk,
	input  logic                        en,
	input  logic [swog_pkg::ROM_AW-1:0] addr,
	output logic [swog_pkg::SINE_W-1:0] data
);
	import swog_pkg::*;

	typedef logic [SINE_W-1:0] sine_rom_t [0:ROM_DEPTH-1];

	// fixed point q60 product of two q60 values
	function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
		al  = {32'd0, a[31:0]};
		ah  = {32'd0, a[63:32]};
		bl  = {32'd0, b[31:0]};
		bh  = {32'd0, b[63:32]};
		ll  = al * bl;
		lh  = al * bh;
		hl  = ah * bl;
		hh  = ah * bh;
		mid = (ll >> 32) + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
		lo  = {32'd0, ll[31:0]} | (mid << 32);
		hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
		return (hi << 4) | (lo >> 60);
	endfunction

	// shift and subtract quotient, only run while the table is built
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo, rem;
		quo = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// taylor series evaluated at elaboration
	function automatic sine_rom_t build_rom();
		sine_rom_t   r;
		logic [63:0] step, x, x2, term, sum, v, den;
		step = 64'h3243F6A8885A308D >> 11;
		for (int k = 0; k < ROM_DEPTH; k++) begin
			x    = 64'(k) * step;
			x2   = q60_mul(x, x);
			term = x;
			sum  = x;
			for (int n = 1; n <= 14; n++) begin
				den  = 64'((2 * n) * (2 * n + 1));
				term = udiv64(q60_mul(term, x2), den);
				if (n[0]) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			v = (sum + (64'd1 << 47)) >> 48;
			if (v > 64'd4096) begin
				v = 64'd4096;
			end
			r[k] = SINE_W'(v);
		end
		return r;
	endfunction

	localparam sine_rom_t SINE_ROM = build_rom();

	always_ff @(posedge clk) begin
		if (en) begin
			data <= SINE_ROM[addr];
		end
	end

endmodule

// ----- sv/swog_env.sv -----
// ----------------------------------------------------------------------------
// swog_env
// per-frame wave phase and amplitude envelope (hold, rise, fall)
// ----------------------------------------------------------------------------
module swog_env (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           frame_step,
	input  swog_pkg::cfg_t cfg,
	output swog_pkg::env_t env
);
	import swog_pkg::*;

	localparam logic [1:0] MODE_HOLD = 2'd0;
	localparam logic [1:0] MODE_RISE = 2'd1;
	localparam logic [1:0] MODE_FALL = 2'd2;

	logic [1:0]         mode_q, mode_d;
	logic [AMP_W-1:0]   amp_q, amp_d, amp_inc;
	logic [ANGLE_W-1:0] phase_q, phase_d;
	logic [TIMER_W-1:0] timer_q, timer_d, timer_inc;

	assign timer_inc = timer_q + TIMER_W'(1);
	assign amp_inc   = amp_q + AMP_W'(1);

	always_comb begin
		mode_d  = mode_q;
		amp_d   = amp_q;
		phase_d = phase_q + cfg.frame_phase_step;
		timer_d = timer_inc;
		case (mode_q)
			MODE_RISE: begin
				if (timer_inc > TIMER_W'(cfg.ramp_interval)) begin
					timer_d = '0;
					amp_d   = amp_inc;
					if (amp_inc > AMP_W'(cfg.peak_amplitude)) begin
						mode_d = MODE_FALL;
					end
				end
			end
			MODE_FALL: begin
				if (timer_inc > TIMER_W'(cfg.ramp_interval)) begin
					timer_d = '0;
					if (amp_q == '0) begin
						phase_d = '0;
						mode_d  = MODE_HOLD;
					end else begin
						amp_d = amp_q - AMP_W'(1);
					end
				end
			end
			default: begin
				// hold, and the unused code behaves the same
				if (timer_inc > TIMER_W'(cfg.hold_frames)) begin
					timer_d = '0;
					mode_d  = MODE_RISE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_HOLD;
			amp_q   <= '0;
			phase_q <= '0;
			timer_q <= '0;
		end else if (frame_step) begin
			mode_q  <= mode_d;
			amp_q   <= amp_d;
			phase_q <= phase_d;
			timer_q <= timer_d;
		end
	end

	assign env.amplitude  = amp_q;
	assign env.wave_phase = phase_q;

`ifndef SYNTHESIS
	a_hold_is_silent: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_HOLD |-> amp_q == '0)
		else $error("amplitude nonzero while holding");

	a_amp_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		amp_q[AMP_W-1] == 1'b0)
		else $error("amplitude beyond peak range");
`endif

endmodule

// ----- sv/scanline_wave_offset_generator.sv -----
// ----------------------------------------------------------------------------
// scanline_wave_offset_generator
// per-scanline horizontal offset: base + amplitude*sin(phase+line*step)/4096
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  ------------------------------------------
//  s_       in   s_tvalid/s_tready  s_tdata[7:0] line_index, s_tlast frame_last
//  m_       out  m_tvalid/m_tready  m_tdata[10:0] x_offset, m_tlast frame_last
//  cfg_     in   cfg_valid/cfg_ready cfg_index register, cfg_data value
//
//  one transaction per cycle in and out while m_tready does not stall; an
//  accepted input transaction loads stage 1 (angle/fold), then passes
//  through the sine table read, the multiply and the offset add into the
//  output register, each a registered stage
//  the sine table read register is one of the four pipeline stages
//  arst_n clears all valids, the envelope state and the configuration
//  registers to their defaults; the table needs no clearing
//  a stall on m_tready holds each occupied stage in place; empty stages
//  still fill, so up to four transactions sit inside while stalled
//
module scanline_wave_offset_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] line_index
	input  logic                          s_tlast,   // frame_last
	// output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,   // [10:0] x_offset, rest zero
	output logic                          m_tlast,   // frame_last
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [swog_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [swog_pkg::CDATA_W-1:0]  cfg_data
);
	import swog_pkg::*;

	// configuration registers
	cfg_t cfg_q;

	// envelope state
	env_t env;
	logic in_acc;

	// stage enables, back to front
	logic en_out, en_s3, en_s2, en_s1;

	// stage 1: folded table address
	logic                v_s1;
	logic [ROM_AW-1:0]   addr_s1;
	logic                neg_s1;
	logic [AMP_W-1:0]    amp_s1;
	logic                last_s1;

	// stage 2: table value
	logic                v_s2;
	logic [SINE_W-1:0]   sin_s2;
	logic                neg_s2;
	logic [AMP_W-1:0]    amp_s2;
	logic                last_s2;

	// stage 3: magnitude of the truncated quotient
	logic                v_s3;
	logic [AMP_W-1:0]    mag_s3;
	logic                neg_s3;
	logic                last_s3;

	// combinational helpers
	logic [LINE_W+ANGLE_W-1:0] line_prod;
	logic [ANGLE_W-1:0]        angle;
	logic [ROM_AW-1:0]         fold_addr;
	logic                      fold_neg;
	logic [AMP_W+SINE_W-1:0]   wave_prod;
	logic [XOFF_W-1:0]         mag_ext, disp, x_off;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_offset      <= 10'h380;   // -128
			cfg_q.line_phase_step  <= 12'd128;
			cfg_q.frame_phase_step <= 12'd64;
			cfg_q.hold_frames      <= 10'd180;
			cfg_q.ramp_interval    <= 4'd3;
			cfg_q.peak_amplitude   <= 8'd80;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BASE_OFFSET: cfg_q.base_offset      <= cfg_data[BASE_W-1:0];
				REG_LINE_STEP:   cfg_q.line_phase_step  <= cfg_data[ANGLE_W-1:0];
				REG_FRAME_STEP:  cfg_q.frame_phase_step <= cfg_data[ANGLE_W-1:0];
				REG_HOLD_FRAMES: cfg_q.hold_frames      <= cfg_data[9:0];
				REG_RAMP_INTVL:  cfg_q.ramp_interval    <= cfg_data[3:0];
				REG_PEAK_AMP:    cfg_q.peak_amplitude   <= cfg_data[7:0];
				default: begin
					// writes beyond the register list are dropped
				end
			endcase
		end
	end

	// a stage advances when it is empty or the stage after it moves
	assign en_out   = !m_tvalid || m_tready;
	assign en_s3    = !v_s3 || en_out;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;
	assign in_acc   = s_tvalid && s_tready;

	// phase and envelope move on the accepted last line of a frame,
	// after that line has taken its own snapshot
	swog_env u_env (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_step (in_acc && s_tlast),
		.cfg        (cfg_q),
		.env        (env)
	);

	// angle for this line, then folded onto the quarter wave
	assign line_prod = s_tdata * cfg_q.line_phase_step;
	assign angle     = (env.wave_phase + line_prod[ANGLE_W-1:0]) & ANGLE_MASK;

	always_comb begin
		if (angle <= ANG_QUARTER) begin
			fold_addr = ROM_AW'(angle);
			fold_neg  = 1'b0;
		end else if (angle <= ANG_HALF) begin
			fold_addr = ROM_AW'(ANG_HALF - angle);
			fold_neg  = 1'b0;
		end else if (angle <= ANG_3QUART) begin
			fold_addr = ROM_AW'(angle - ANG_HALF);
			fold_neg  = 1'b1;
		end else begin
			fold_addr = ROM_AW'(ANG_TURN - {1'b0, angle});
			fold_neg  = 1'b1;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_acc;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_out) begin
				m_tvalid <= v_s3;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (en_s1) begin
			addr_s1 <= fold_addr;
			neg_s1  <= fold_neg;
			amp_s1  <= env.amplitude;
			last_s1 <= s_tlast;
		end
	end

	// stage 2: table read lands here
	swog_sine_rom u_rom (
		.clk  (clk),
		.en   (en_s2),
		.addr (addr_s1),
		.data (sin_s2)
	);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			neg_s2  <= neg_s1;
			amp_s2  <= amp_s1;
			last_s2 <= last_s1;
		end
	end

	// stage 3: product of magnitudes, so the shift truncates toward zero
	assign wave_prod = amp_s2 * sin_s2;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			mag_s3  <= wave_prod[12 +: AMP_W];
			neg_s3  <= neg_s2;
			last_s3 <= last_s2;
		end
	end

	// output register: apply the sign and add the base offset
	assign mag_ext = {{(XOFF_W-AMP_W){1'b0}}, mag_s3};
	assign disp    = neg_s3 ? (XOFF_W'(0) - mag_ext) : mag_ext;
	assign x_off   = {cfg_q.base_offset[BASE_W-1], cfg_q.base_offset} + disp;

	always_ff @(posedge clk) begin
		if (en_out) begin
			m_tdata <= {5'd0, x_off};
			m_tlast <= last_s3;
		end
	end

`ifndef SYNTHESIS
	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !en_s3 |=> v_s3 && $stable(mag_s3) && $stable(neg_s3))
		else $error("stage 3 lost its item while stalled");

	a_out_from_s3: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(v_s3))
		else $error("output valid without a stage 3 item");

	a_empty_s1_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> s_tready)
		else $error("input stalled with stage 1 empty");
`endif

endmodule
